// ===== rtl/core/llas_pkg.sv =====
// Shared types and constants of the life-like automaton step block.
package llas_pkg;

    localparam int MAX_COLS = 64;
    localparam int MAX_ROWS = 64;
    localparam int COL_W    = $clog2(MAX_COLS);
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int DIM_W    = 7;

    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_ADVANCE = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        REG_BIRTH    = 3'd0,
        REG_SURVIVAL = 3'd1,
        REG_WIDTH    = 3'd2,
        REG_HEIGHT   = 3'd3,
        REG_WRAP     = 3'd4
    } t_reg_idx;

    // Classified command as it travels from front to back
    typedef struct packed {
        t_cmd             cmd;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             cell_val;
        logic             in_grid;
    } t_op;

    // Configuration with the grid size already clamped
    typedef struct packed {
        logic [8:0]       birth;
        logic [8:0]       surv;
        logic [DIM_W-1:0] w_eff;
        logic [DIM_W-1:0] h_eff;
        logic             wrap;
    } t_cfg;

endpackage

// ===== rtl/core/life_like_automaton_step_top.sv =====
// Top level of the life-like automaton step block: config, front, back, grid RAM.
// Holds up to a 64 by 64 grid of one-bit cells, stored as one 64-bit RAM word per
// row, and runs commands in order: write a cell, read a cell, or advance one
// generation under the birth and survival masks. A read or write passes through the
// back end's cell and output states; a generation of a w by h grid is run by the back
// end scoring one cell per cycle, row by row, and writing each row back. A
// two-entry queue lets commands be accepted while the back end works. Rows are
// cleared at reset by per-row valid bits, so there is no clearing pass; configuration
// writes are taken at any time and must only be issued while the block is idle.
module life_like_automaton_step_top import llas_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // col[5:0], row[11:6], cell_in[12], zero pad
    input  logic [1:0]  s_axis_tuser,  // command[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // cell_out[0], changed[1], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    logic [8:0]          r_birth, r_surv;
    logic [DIM_W-1:0]    r_width, r_height;
    logic                r_wrap;
    t_cfg                cfg;
    logic                q_vld, q_pop;
    t_op                 q_op;
    logic                ram_we;
    logic [ROW_W-1:0]    ram_waddr, ram_raddr;
    logic [MAX_COLS-1:0] ram_wdata, ram_rdata;
    logic                o_cell, o_chg;

    assign o_cfg_ready = 1'b1;

    // Hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_birth  <= 9'd72;
            r_surv   <= 9'd12;
            r_width  <= DIM_W'(MAX_COLS);
            r_height <= DIM_W'(MAX_ROWS);
            r_wrap   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (t_reg_idx'(i_cfg_index))
                REG_BIRTH:    r_birth  <= i_cfg_data;
                REG_SURVIVAL: r_surv   <= i_cfg_data;
                REG_WIDTH:    r_width  <= i_cfg_data[DIM_W-1:0];
                REG_HEIGHT:   r_height <= i_cfg_data[DIM_W-1:0];
                REG_WRAP:     r_wrap   <= i_cfg_data[0];
                default:      r_wrap   <= r_wrap;
            endcase
        end
    end

    // Clamp grid size
    always_comb begin
        cfg.birth = r_birth;
        cfg.surv  = r_surv;
        cfg.w_eff = (r_width  > DIM_W'(MAX_COLS)) ? DIM_W'(MAX_COLS) : r_width;
        cfg.h_eff = (r_height > DIM_W'(MAX_ROWS)) ? DIM_W'(MAX_ROWS) : r_height;
        cfg.wrap  = r_wrap;
    end

    llas_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_cmd   (s_axis_tuser),
        .i_col   (s_axis_tdata[5:0]),
        .i_row   (s_axis_tdata[11:6]),
        .i_cell  (s_axis_tdata[12]),
        .o_q_vld (q_vld),
        .o_q_op  (q_op),
        .i_q_pop (q_pop)
    );

    llas_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_q_vld     (q_vld),
        .i_q_op      (q_op),
        .o_q_pop     (q_pop),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_cell      (o_cell),
        .o_changed   (o_chg)
    );

    llas_ram #(
        .WIDTH (MAX_COLS),
        .DEPTH (MAX_ROWS)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign m_axis_tdata = {6'd0, o_chg, o_cell};

`ifndef SYNTHESIS
    // Never pop an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_vld) else $error("pop from empty command queue");

    // Row writes stay inside the rows in use
    a_write_in_grid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> ({1'b0, ram_waddr} < cfg.h_eff)) else $error("row write outside grid");

    // A stalled result holds its value
    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result dropped while stalled");
`endif

endmodule

// ===== rtl/core/llas_ram.sv =====
// Generic one-write one-read RAM with registered read data.
module llas_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write and read the array
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/llas_front.sv =====
// Front end: accepts commands, flags whether they hit the grid, queues them.
module llas_front import llas_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cfg             i_cfg,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [1:0]       i_cmd,
    input  logic [COL_W-1:0] i_col,
    input  logic [ROW_W-1:0] i_row,
    input  logic             i_cell,
    output logic             o_q_vld,
    output t_op              o_q_op,
    input  logic             i_q_pop
);

    t_op        r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_op        op_in;
    logic       push;

    // Classify the incoming command
    always_comb begin
        op_in.cmd      = t_cmd'(i_cmd);
        op_in.col      = i_col;
        op_in.row      = i_row;
        op_in.cell_val = i_cell;
        op_in.in_grid  = ({1'b0, i_col} < i_cfg.w_eff) && ({1'b0, i_row} < i_cfg.h_eff);
    end

    assign o_ready = (r_cnt != 2'd2);
    assign push    = i_valid && o_ready;
    assign o_q_vld = (r_cnt != 2'd0);
    assign o_q_op  = r_mem[r_rp];

    // Hold queued commands
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= op_in;
        end
    end

    // Advance queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_q_pop};
        end
    end

endmodule

// ===== rtl/core/llas_back.sv =====
// Back end: carries out cell reads, writes and generations on the row RAM.
module llas_back import llas_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_vld,
    input  t_op                 i_q_op,
    output logic                o_q_pop,
    output logic                o_ram_we,
    output logic [ROW_W-1:0]    o_ram_waddr,
    output logic [MAX_COLS-1:0] o_ram_wdata,
    output logic [ROW_W-1:0]    o_ram_raddr,
    input  logic [MAX_COLS-1:0] i_ram_rdata,
    output logic                o_valid,
    input  logic                i_ready,
    output logic                o_cell,
    output logic                o_changed
);

    typedef enum logic [3:0] {
        S_IDLE, S_CELL, S_OUT, S_G_TOP, S_G_CUR, S_G_NXT, S_G_LOAD, S_G_RUN, S_G_WB
    } t_state;

    t_state              r_state;
    t_op                 r_op;
    logic [MAX_ROWS-1:0] r_row_vld;
    logic [ROW_W-1:0]    r_rd_row;
    logic [MAX_COLS-1:0] r_prev, r_cur, r_nxt, r_save0, r_new;
    logic [COL_W-1:0]    r_x;
    logic [ROW_W-1:0]    r_y;
    logic                r_chg;
    logic                r_res_cell, r_res_chg;
    logic                r_ovld, r_ocell, r_ochg;

    logic [MAX_COLS-1:0] rd;
    logic [ROW_W-1:0]    raddr;
    logic                we;
    logic [ROW_W-1:0]    waddr;
    logic [MAX_COLS-1:0] wdata;
    logic                slot_free;
    logic [COL_W-1:0]    xl, xr, wlast;
    logic                vl, vr, alive, nb;
    logic [3:0]          cnt;
    logic [DIM_W-1:0]    y1;

    // Mask rows never written since reset
    assign rd        = r_row_vld[r_rd_row] ? i_ram_rdata : '0;
    assign slot_free = !r_ovld || i_ready;
    assign wlast     = COL_W'(i_cfg.w_eff - DIM_W'(1));
    assign y1        = {1'b0, r_y} + DIM_W'(1);

    // Neighbor columns, neighbor count and next state of the current cell
    always_comb begin
        if (i_cfg.wrap) begin
            xl = (r_x == '0) ? wlast : r_x - COL_W'(1);
            xr = ({1'b0, r_x} + DIM_W'(1) >= i_cfg.w_eff) ? '0 : r_x + COL_W'(1);
            vl = 1'b1;
            vr = 1'b1;
        end else begin
            xl = r_x - COL_W'(1);
            xr = r_x + COL_W'(1);
            vl = (r_x != '0);
            vr = ({1'b0, r_x} + DIM_W'(1) < i_cfg.w_eff);
        end
        cnt = 4'(r_prev[r_x]) + 4'(r_nxt[r_x])
            + 4'(r_prev[xl] & vl) + 4'(r_cur[xl] & vl) + 4'(r_nxt[xl] & vl)
            + 4'(r_prev[xr] & vr) + 4'(r_cur[xr] & vr) + 4'(r_nxt[xr] & vr);
        alive = r_cur[r_x];
        nb    = alive ? i_cfg.surv[cnt] : i_cfg.birth[cnt];
    end

    // Drive RAM address and write port
    always_comb begin
        raddr = r_rd_row;
        we    = 1'b0;
        waddr = r_op.row;
        wdata = rd;
        case (r_state)
            S_IDLE:  raddr = i_q_op.row;
            S_G_TOP: raddr = ROW_W'(i_cfg.h_eff - DIM_W'(1));
            S_G_CUR: raddr = '0;
            S_G_NXT: raddr = ROW_W'(1);
            S_G_WB:  raddr = ROW_W'({1'b0, r_y} + DIM_W'(2));
            S_CELL: begin
                if (r_op.cmd == CMD_WRITE && r_op.in_grid) begin
                    we           = 1'b1;
                    wdata[r_op.col] = r_op.cell_val;
                end
            end
            default: raddr = r_rd_row;
        endcase
        if (r_state == S_G_WB) begin
            we    = 1'b1;
            waddr = r_y;
            wdata = r_new;
        end
    end

    assign o_q_pop     = (r_state == S_IDLE) && i_q_vld;
    assign o_ram_we    = we;
    assign o_ram_waddr = waddr;
    assign o_ram_wdata = wdata;
    assign o_ram_raddr = raddr;
    assign o_valid     = r_ovld;
    assign o_cell      = r_ocell;
    assign o_changed   = r_ochg;

    // Hold state, datapath and the output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_ovld    <= 1'b0;
            r_rd_row  <= '0;
        end else begin
            r_rd_row <= raddr;
            if (we) begin
                r_row_vld[waddr] <= 1'b1;
            end
            if (r_ovld && i_ready && r_state != S_OUT) begin
                r_ovld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_q_vld) begin
                        r_op       <= i_q_op;
                        r_res_cell <= 1'b0;
                        r_res_chg  <= 1'b0;
                        r_chg      <= 1'b0;
                        r_y        <= '0;
                        if (i_q_op.cmd == CMD_ADVANCE) begin
                            if (i_cfg.w_eff == '0 || i_cfg.h_eff == '0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_G_TOP;
                            end
                        end else begin
                            r_state <= S_CELL;
                        end
                    end
                end
                S_CELL: begin
                    r_res_cell <= (r_op.cmd == CMD_READ) && r_op.in_grid && rd[r_op.col];
                    r_state    <= S_OUT;
                end
                S_OUT: begin
                    if (slot_free) begin
                        r_ovld  <= 1'b1;
                        r_ocell <= r_res_cell;
                        r_ochg  <= r_res_chg;
                        r_state <= S_IDLE;
                    end
                end
                S_G_TOP: r_state <= S_G_CUR;
                S_G_CUR: begin
                    r_prev  <= i_cfg.wrap ? rd : '0;
                    r_state <= S_G_NXT;
                end
                S_G_NXT: begin
                    r_cur   <= rd;
                    r_save0 <= rd;
                    r_state <= S_G_LOAD;
                end
                S_G_LOAD: begin
                    if (y1 < i_cfg.h_eff) begin
                        r_nxt <= rd;
                    end else begin
                        r_nxt <= i_cfg.wrap ? r_save0 : '0;
                    end
                    r_new   <= r_cur;
                    r_x     <= '0;
                    r_state <= S_G_RUN;
                end
                S_G_RUN: begin
                    r_new[r_x] <= nb;
                    if (nb != alive) begin
                        r_chg <= 1'b1;
                    end
                    if (r_x == wlast) begin
                        r_state <= S_G_WB;
                    end else begin
                        r_x <= r_x + COL_W'(1);
                    end
                end
                S_G_WB: begin
                    r_prev <= r_cur;
                    r_cur  <= r_nxt;
                    if (y1 >= i_cfg.h_eff) begin
                        r_res_chg <= r_chg;
                        r_state   <= S_OUT;
                    end else begin
                        r_y     <= r_y + ROW_W'(1);
                        r_state <= S_G_LOAD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
